>>> rtl/bldu_pkg.sv
package bldu_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_KEY   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd4;

    localparam logic [ST_W-1:0] STAT_DONE = 2'd0;
    localparam logic [ST_W-1:0] STAT_NONE = 2'd1;
    localparam logic [ST_W-1:0] STAT_FULL = 2'd2;
    localparam logic [ST_W-1:0] STAT_DUMP = 2'd3;

    typedef struct packed {
        logic             cap;
        logic             ins;
        logic             del;
        logic [KEY_W-1:0] key;
    } t_cell_cmd;

endpackage

>>> rtl/bldu_if.sv
interface bldu_in_if;
    import bldu_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key_value;

    modport source (output valid, output opcode, output key_value, input ready);
    modport sink   (input valid, input opcode, input key_value, output ready);
endinterface

interface bldu_out_if;
    import bldu_pkg::*;
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] out_key;
    logic             entry_present;
    logic             last_result;

    modport source (output valid, output status, output out_key, output entry_present,
                    output last_result, input ready);
    modport sink   (input valid, input status, input out_key, input entry_present,
                    input last_result, output ready);
endinterface

>>> rtl/bldu_cell.sv
module bldu_cell
    import bldu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_cmd        i_cmd,
    input  logic             i_valid,
    input  logic [KEY_W-1:0] i_left_key,
    input  logic [KEY_W-1:0] i_right_key,
    input  logic             i_found,
    output logic             o_found,
    output logic [KEY_W-1:0] o_key
);

    logic [KEY_W-1:0] r_key, n_key;
    logic             r_match, n_match;

    // found ripples front to back; this cell and all behind it shift left
    assign o_found = i_found | r_match;
    assign o_key   = r_key;

    always_comb begin
        n_match = r_match;
        n_key   = r_key;
        if (i_cmd.cap) begin
            n_match = i_valid && (r_key == i_cmd.key);
        end
        if (i_cmd.ins) begin
            n_key = i_left_key;
        end else if (i_cmd.del && o_found) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
        r_key <= n_key;
    end

endmodule

>>> rtl/bounded_list_with_key_delete_unit.sv
// Flow: an insert or delete word is taken in the idle state and its result is loaded into
// the output register from the EXEC state, which waits while the output register is full.
// A dump passes through EXEC (one empty dump result when the list is empty) to DUMP,
// which loads one stored key per cycle while the output is free. Throughput is one word at a time.
// Reset (synchronous, active low) empties the list; no clearing pass is needed.
module bounded_list_with_key_delete_unit
    import bldu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bldu_in_if.sink    i_in,
    bldu_out_if.source o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [OP_W-1:0]  r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic             r_ov, n_ov;
    logic [ST_W-1:0]  r_status, n_status;
    logic [KEY_W-1:0] r_okey, n_okey;
    logic             r_present, n_present;
    logic             r_last, n_last;

    t_cell_cmd        w_cmd;
    logic             w_first;
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY:0]   w_found;
    logic [KEY_W-1:0] w_keys [CAPACITY];
    logic             w_accept;
    logic             w_out_free;
    logic             w_dump_last;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_ov || o_out.ready;
    assign w_found[0]  = w_first;
    assign w_dump_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    genvar g;
    for (g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_valid[g] = (CNT_W'(g) < r_count);
        bldu_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_valid     (w_valid[g]),
            .i_left_key  ((g == 0) ? r_key : w_keys[(g == 0) ? 0 : g - 1]),
            .i_right_key ((g == CAPACITY - 1) ? '0 : w_keys[(g == CAPACITY - 1) ? g : g + 1]),
            .i_found     (w_found[g]),
            .o_found     (w_found[g+1]),
            .o_key       (w_keys[g])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_count   = r_count;
        n_idx     = r_idx;
        n_ov      = r_ov && !o_out.ready;
        n_status  = r_status;
        n_okey    = r_okey;
        n_present = r_present;
        n_last    = r_last;
        w_cmd.cap = w_accept;
        w_cmd.ins = 1'b0;
        w_cmd.del = 1'b0;
        w_cmd.key = i_in.key_value;
        w_first   = 1'b0;
        i_in.ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_in.opcode;
                    n_key   = i_in.key_value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_ov      = 1'b1;
                    n_status  = STAT_NONE;
                    n_okey    = '0;
                    n_present = 1'b0;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                    case (r_op)
                        OP_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_cmd.ins = 1'b1;
                                n_count   = r_count + CNT_W'(1);
                                n_status  = STAT_DONE;
                            end
                        end
                        OP_DEL_KEY: begin
                            if (w_found[CAPACITY]) begin
                                w_cmd.del = 1'b1;
                                n_count   = r_count - CNT_W'(1);
                                n_status  = STAT_DONE;
                            end
                        end
                        OP_DEL_FIRST: begin
                            if (r_count != '0) begin
                                w_cmd.del = 1'b1;
                                w_first   = 1'b1;
                                n_count   = r_count - CNT_W'(1);
                                n_status  = STAT_DONE;
                            end
                        end
                        OP_DEL_LAST: begin
                            if (r_count != '0) begin
                                n_count  = r_count - CNT_W'(1);
                                n_status = STAT_DONE;
                            end
                        end
                        OP_DUMP: begin
                            n_status = STAT_DUMP;
                            if (r_count != '0) begin
                                n_ov    = r_ov && !o_out.ready;
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            n_status = STAT_NONE;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    n_ov      = 1'b1;
                    n_status  = STAT_DUMP;
                    n_okey    = w_keys[r_idx];
                    n_present = 1'b1;
                    n_last    = w_dump_last;
                    n_idx     = r_idx + IDX_W'(1);
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
        r_op      <= n_op;
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_okey    <= n_okey;
        r_present <= n_present;
        r_last    <= n_last;
    end

    assign o_out.valid         = r_ov;
    assign o_out.status        = r_status;
    assign o_out.out_key       = r_okey;
    assign o_out.entry_present = r_present;
    assign o_out.last_result   = r_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_dump_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (CNT_W'(r_idx) < r_count))
        else $error("dump index past end of list");

    a_dump_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> $stable(r_count))
        else $error("list changed during dump");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.ins && w_cmd.del))
        else $error("insert and delete shift at once");
`endif

endmodule
